>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the indexed list block.
// Relies on each including module having clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ilist_pkg.sv
// Package for the indexed list block: command codes, item structs and the
// controller-to-datapath command struct. No dependencies.
package ilist_pkg;

  localparam int unsigned PosW   = 5;
  localparam int unsigned ValueW = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [PosW-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
    logic              op_failed;
    logic              error_seen;
  } out_item_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

endpackage

>>> rtl/ilist_ctrl.sv
// Controller for the indexed list block: tracks the result register and
// issues the execute command. Depends on ilist_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ilist_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ilist_pkg::ctrl_cmd_t   cmd_o
);

  ilist_pkg::state_e state_q, state_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilist_pkg::ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_stall_o  = (state_q == ilist_pkg::ST_FULL) && out_stall_i;
    out_valid_o = (state_q == ilist_pkg::ST_FULL);
    accept      = in_valid_i && !in_stall_o;
    cmd_o.exec  = accept;
    state_d     = state_q;
    case (state_q)
      ilist_pkg::ST_EMPTY: begin
        if (accept) state_d = ilist_pkg::ST_FULL;
      end
      ilist_pkg::ST_FULL: begin
        if (!accept && !out_stall_i) state_d = ilist_pkg::ST_EMPTY;
      end
      default: state_d = ilist_pkg::ST_EMPTY;
    endcase
  end

  `ASSERT_NEXT(a_exec_loads, cmd_o.exec, out_valid_o, "executed item left no result")
  `ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o,
               "stalled result dropped")

endmodule

>>> rtl/ilist_dp.sv
// Datapath for the indexed list block: shifting entry cells, entry count,
// sticky error flag and result register. Depends on ilist_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ilist_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ilist_pkg::ctrl_cmd_t  cmd_i,
  input  ilist_pkg::in_item_t   in_data_i,
  output ilist_pkg::out_item_t  out_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > ilist_pkg::PosW) ? CW : ilist_pkg::PosW;

  logic [ilist_pkg::ValueW-1:0] cell_q [DEPTH];
  logic [ilist_pkg::ValueW-1:0] cell_d [DEPTH];
  logic [CW-1:0]                count_q, count_d;
  logic                         sticky_q, sticky_d;
  ilist_pkg::out_item_t         res_q, res_d;

  logic [MW-1:0]                pos_w, cnt_w, cnt_after;
  logic                         ins_ok, idx_ok, failed;
  logic [ilist_pkg::ValueW-1:0] rd_val;

  always_comb begin
    pos_w  = MW'(in_data_i.position);
    cnt_w  = MW'(count_q);
    ins_ok = (pos_w <= cnt_w) && (cnt_w < MW'(DEPTH));
    idx_ok = (pos_w < cnt_w);

    rd_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (MW'(i) == pos_w) rd_val = cell_q[i];
    end

    cell_d  = cell_q;
    count_d = count_q;
    failed  = 1'b0;
    res_d   = res_q;

    case (ilist_pkg::cmd_e'(in_data_i.cmd))
      ilist_pkg::CMD_INSERT: begin
        if (ins_ok) begin
          // open a gap at the index, later entries move back one cell
          for (int i = 1; i < DEPTH; i++) begin
            if (MW'(i) > pos_w) cell_d[i] = cell_q[i-1];
          end
          for (int i = 0; i < DEPTH; i++) begin
            if (MW'(i) == pos_w) cell_d[i] = cnt_w[ilist_pkg::ValueW-1:0];
          end
          count_d = count_q + CW'(1);
        end else begin
          failed = 1'b1;
        end
      end
      ilist_pkg::CMD_DELETE: begin
        if (idx_ok) begin
          // close the gap, later entries move forward one cell
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (MW'(i) >= pos_w) cell_d[i] = cell_q[i+1];
          end
          count_d = count_q - CW'(1);
        end else begin
          failed = 1'b1;
        end
      end
      ilist_pkg::CMD_READ: begin
        failed = !idx_ok;
      end
      default: ;
    endcase

    sticky_d  = sticky_q | failed;
    cnt_after = MW'(count_d);

    res_d.value = ((ilist_pkg::cmd_e'(in_data_i.cmd) == ilist_pkg::CMD_READ) && idx_ok)
                  ? rd_val : '0;
    res_d.count      = cnt_after[ilist_pkg::CountW-1:0];
    res_d.op_failed  = failed;
    res_d.error_seen = sticky_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sticky_q <= 1'b0;
    end else if (cmd_i.exec) begin
      count_q  <= count_d;
      sticky_q <= sticky_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cell_q <= cell_d;
      res_q  <= res_d;
    end
  end

  assign out_data_o = res_q;

  `ASSERT_CLK(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  `ASSERT_NEXT(a_sticky_holds, sticky_q, sticky_q, "sticky error cleared")
  `ASSERT_NEXT(a_fail_unchanged, cmd_i.exec && failed, count_q == $past(count_q),
               "failed command changed the count")

endmodule

>>> rtl/indexed_list_insert_delete.sv
// Top level of the indexed list block: ordered list with insert, delete and
// read at an index. Depends on ilist_pkg, ilist_ctrl and ilist_dp.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one command item
//   (cmd: insert, delete or read; position: zero-based index). Output channel
//   out_valid_o / out_stall_i / out_data_o returns exactly one result item per
//   command: read value, entry count after the command, per-command failure bit
//   and the sticky error flag.
//   The result appears in the cycle after the item is accepted.
//   Throughput: one item per cycle unless stalled; every cell shifts or holds in
//   parallel on a compare of its own index with the position, and the result
//   register is loaded in the same cycle, so the single-entry result register
//   sets the rate. A new item is taken while the previous result is being taken.
//   Stall: while out_stall_i holds a pending result, in_stall_o is raised and
//   the result is held unchanged; no item is lost or repeated.
//   Reset: rst_ni (async, active low) empties the list, clears the sticky error
//   and drops any pending result. Entry cells are not cleared; an entry is only
//   read once it has been written.
//   Insert writes the entry count (low four bits) at the index. Out-of-range
//   indexes and inserts into a full list fail without changing the list.

module indexed_list_insert_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ilist_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ilist_pkg::out_item_t  out_data_o
);

  ilist_pkg::ctrl_cmd_t ctrl_cmd;

  // handshake control: accept, hold or release the result register
  ilist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctrl_cmd)
  );

  // list cells, count, sticky error and result register
  ilist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> verif/indexed_list_insert_delete_test.sv
// Self-checking testbench for indexed_list_insert_delete: insert, delete and read
// commands at an index, checked against an in-bench prediction of the list.
// Depends on ilist_pkg and the indexed_list_insert_delete RTL.
module indexed_list_insert_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;  // no operation behind this code
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned QUIET_LIMIT  = 1000;  // cycles with no handshake at all
  localparam int unsigned LONG_HOLD    = 80;    // one long receiver hold-off
  localparam int unsigned HOLD_AFTER   = 400;   // results checked before that hold
  localparam int unsigned END_CYCLES   = 4;

  typedef enum {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  // One queued command; drain_first holds it back until no result is owed.
  typedef struct {
    ilist_pkg::in_item_t item;
    bit                  drain_first;
  } list_cmd_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  ilist_pkg::in_item_t  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ilist_pkg::out_item_t out_data_o;

  indexed_list_insert_delete #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Commands waiting to be offered, and results owed by the block, oldest first.
  list_cmd_t            commands_todo[$];
  ilist_pkg::out_item_t results_due[$];

  // Predicted list contents, mirrored from the accepted commands.
  logic [ilist_pkg::ValueW-1:0] list_entries [DEPTH];
  int                           list_count = 0;
  logic                         list_error = 1'b0;

  // Count of entries as seen by the stimulus planner (updated as commands queue).
  int                plan_count = 0;

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned n_cmds [4]      = '{default: 0};
  int unsigned n_failed        = 0;
  int unsigned n_full          = 0;
  int unsigned n_emptied       = 0;
  logic        cmd_taken       = 1'b0;

  // Apply one command to the predicted list and return the result it owes.
  function automatic ilist_pkg::out_item_t apply_command(ilist_pkg::in_item_t c);
    ilist_pkg::out_item_t r;
    bit                   failed;
    int                   pos;
    r      = '0;
    failed = 1'b0;
    pos    = int'(c.position);
    case (c.cmd)
      ilist_pkg::CMD_INSERT: begin
        if (pos > list_count || list_count >= DEPTH) begin
          failed = 1'b1;
        end else begin
          for (int i = list_count; i > pos; i--) list_entries[i] = list_entries[i-1];
          list_entries[pos] = ilist_pkg::ValueW'(list_count);
          list_count++;
        end
      end
      ilist_pkg::CMD_DELETE: begin
        if (pos >= list_count) begin
          failed = 1'b1;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
          list_count--;
        end
      end
      ilist_pkg::CMD_READ: begin
        if (pos >= list_count) failed = 1'b1;
        else r.value = list_entries[pos];
      end
      default: ;  // unused code: leave everything alone
    endcase
    if (failed) list_error = 1'b1;
    r.count      = ilist_pkg::CountW'(list_count);
    r.op_failed  = failed;
    r.error_seen = list_error;
    return r;
  endfunction

  // Queue one command and advance the planner's view of the entry count.
  task automatic queue_cmd(logic [1:0] cmd, int pos, bit drain_first);
    list_cmd_t lc;
    lc.item.cmd      = cmd;
    lc.item.position = ilist_pkg::PosW'(pos);
    lc.drain_first   = drain_first;
    commands_todo.push_back(lc);
    if (cmd == ilist_pkg::CMD_INSERT && pos <= plan_count && plan_count < DEPTH)
      plan_count++;
    else if (cmd == ilist_pkg::CMD_DELETE && pos < plan_count)
      plan_count--;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: sample both handshakes at the rising edge. Check the result side
  // first so a result is always matched against the item that caused it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result with nothing expected: value %0d count %0d fail %0b err %0b",
                   $time, out_data_o.value, out_data_o.count, out_data_o.op_failed,
                   out_data_o.error_seen);
          mismatches++;
        end else begin
          ilist_pkg::out_item_t want;
          want = results_due.pop_front();
          check_field("value",      8'(want.value),      8'(out_data_o.value));
          check_field("count",      8'(want.count),      8'(out_data_o.count));
          check_field("op_failed",  8'(want.op_failed),  8'(out_data_o.op_failed));
          check_field("error_seen", 8'(want.error_seen), 8'(out_data_o.error_seen));
        end
        results_checked++;
      end
      if (in_valid_i && !in_stall_o) begin
        ilist_pkg::out_item_t owed;
        owed = apply_command(in_data_i);
        results_due.push_back(owed);
        n_cmds[in_data_i.cmd]++;
        if (owed.op_failed) n_failed++;
        if (in_data_i.cmd == ilist_pkg::CMD_INSERT && !owed.op_failed &&
            list_count == DEPTH) n_full++;
        if (in_data_i.cmd == ilist_pkg::CMD_DELETE && !owed.op_failed &&
            list_count == 0) n_emptied++;
      end
      // Count cycles with no handshake on either side for the watchdog.
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles = 0;
      else quiet_cycles++;
      cmd_taken <= in_valid_i && !in_stall_o;
    end
  end

  // Driver: offer commands in bursts with random gaps. Hold the current item
  // until it is taken; change inputs only at the falling edge.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  logic        drv_send;
  list_cmd_t   drv_next;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || cmd_taken)) begin
      drv_send = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (commands_todo.size() > 0 &&
                   !(commands_todo[0].drain_first && results_due.size() != 0)) begin
        drv_send = 1'b1;
      end
      if (drv_send) begin
        drv_next = commands_todo.pop_front();
        in_data_i <= drv_next.item;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Pick the next burst; about half of them run straight into the next.
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(9))
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7:       gap_left = $urandom_range(1, 3);
            default:       gap_left = $urandom_range(4, 12);
          endcase
        end
      end
      in_valid_i <= drv_send;
    end
  end

  // Receiver: stall on a pattern that changes every stretch, plus one long
  // hold-off that lets the block fill up and push back on the sender.
  rx_mode_e    rx_mode     = RX_OPEN;
  int unsigned rx_seg_left = 0;
  int unsigned rx_period   = 2;
  int unsigned rx_cycle    = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  logic        rx_stall;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        rx_stall = 1'b1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rx_stall  = 1'b1;
      end else begin
        if (rx_seg_left == 0) begin
          rx_mode     = rx_mode_e'($urandom_range(3));
          rx_seg_left = $urandom_range(20, 150);
          rx_period   = $urandom_range(2, 6);
        end else begin
          rx_seg_left--;
        end
        case (rx_mode)
          RX_OPEN:     rx_stall = 1'b0;
          RX_LIGHT:    rx_stall = ($urandom_range(3) == 0);
          RX_PERIODIC: rx_stall = ((rx_cycle % rx_period) == 0);
          default:     rx_stall = ($urandom_range(3) != 0);
        endcase
      end
      out_stall_i <= rx_stall;
    end
  end

  // Watchdog: end the run if the handshakes stop moving.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t ns: no handshake for %0d cycles, %0d results still owed",
             $time, QUIET_LIMIT, results_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus plan, reset, and the end of the run.
  initial begin
    bit         filling;
    int         roll;
    int         pos;
    logic [1:0] op;

    // Directed: failures on an empty list, the unused code, deleting the only
    // entry, a fill to DEPTH at front, back and middle, then the full-list cases.
    queue_cmd(ilist_pkg::CMD_READ,   0,  1'b0);
    queue_cmd(ilist_pkg::CMD_DELETE, 0,  1'b0);
    queue_cmd(CMD_UNUSED,            16, 1'b0);
    queue_cmd(ilist_pkg::CMD_INSERT, 1,  1'b0);
    queue_cmd(ilist_pkg::CMD_INSERT, 0,  1'b0);
    queue_cmd(ilist_pkg::CMD_DELETE, 0,  1'b0);
    for (int k = 0; k < DEPTH; k++) begin
      if (k % 3 == 0) queue_cmd(ilist_pkg::CMD_INSERT, 0, 1'b0);
      else if (k % 3 == 1) queue_cmd(ilist_pkg::CMD_INSERT, k, 1'b0);
      else queue_cmd(ilist_pkg::CMD_INSERT, k / 2, 1'b0);
    end
    queue_cmd(ilist_pkg::CMD_INSERT, 16,        1'b0);
    queue_cmd(ilist_pkg::CMD_READ,   16,        1'b0);
    queue_cmd(ilist_pkg::CMD_DELETE, DEPTH - 1, 1'b0);

    // Random: swing the list between empty and full, mostly with in-range
    // indexes, with some out-of-range ones and a rare unused code mixed in.
    filling = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (plan_count == DEPTH) filling = 1'b0;
      else if (plan_count == 0) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = !filling;
      roll = $urandom_range(99);
      if (roll == 0) op = CMD_UNUSED;
      else if (roll < 25) op = ilist_pkg::CMD_READ;
      else if ($urandom_range(99) < (filling ? 78 : 22)) op = ilist_pkg::CMD_INSERT;
      else op = ilist_pkg::CMD_DELETE;
      if (op == CMD_UNUSED || $urandom_range(99) < 10)
        pos = $urandom_range(16);
      else if (op == ilist_pkg::CMD_INSERT)
        pos = (plan_count < DEPTH) ? $urandom_range(plan_count) : $urandom_range(16);
      else
        pos = (plan_count > 0) ? $urandom_range(plan_count - 1) : $urandom_range(16);
      // Let the pipe run dry before a few commands.
      queue_cmd(op, pos, n == 0 || n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3);
    end

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (commands_todo.size() != 0 || in_valid_i || results_due.size() != 0)
      @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (results_due.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, results_due.size());
      mismatches++;
    end

    $display("Covered %0d inserts, %0d deletes, %0d reads and %0d unused codes; %0d failed.",
             n_cmds[ilist_pkg::CMD_INSERT], n_cmds[ilist_pkg::CMD_DELETE],
             n_cmds[ilist_pkg::CMD_READ], n_cmds[CMD_UNUSED], n_failed);
    $display("List filled %0d times, emptied %0d times; %0d results checked, %0d mismatches.",
             n_full, n_emptied, results_checked, mismatches);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
